[src/efps_pkg.sv]
// ----------------------------------------------------------------------------
// efps_pkg
// Shared types and constants of the moving-average percent scaler.
// ----------------------------------------------------------------------------
package efps_pkg;

  localparam int LOW_BITS     = 14;
  localparam int OFFSET_BITS  = 13;
  localparam int LEVEL_BITS   = 22;
  localparam int PCT_BITS     = 15;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [PCT_BITS-1:0] PERCENT_FULL = 15'd25600;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WEIGHT,
    CFG_LOW,
    CFG_HIGH,
    CFG_OFFSET
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_RAW,
    MODE_ZERO,
    MODE_SCALE,
    MODE_INVERT
  } mode_t;

  typedef struct packed {
    logic signed [LOW_BITS-1:0]    range_low;
    logic signed [LOW_BITS-1:0]    range_high;
    logic signed [OFFSET_BITS-1:0] reading_offset;
  } cfg_t;

endpackage

[src/efps_fifo.sv]
// ----------------------------------------------------------------------------
// efps_fifo
// Short word queue between the filter front and the scaling back end.
// ----------------------------------------------------------------------------
module efps_fifo #(
  parameter int W     = 30,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/efps_front.sv]
// ----------------------------------------------------------------------------
// efps_front
// Accepts samples, updates the moving average and classifies the output mode.
// ----------------------------------------------------------------------------
module efps_front #(
  parameter int SAMPLE_BITS      = 12,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [SAMPLE_BITS-1:0]                 raw_sample,
  input  logic                                   restart,
  input  logic [WEIGHT_FRAC_BITS:0]              weight,
  input  efps_pkg::cfg_t                         cfg,
  output logic                                   q_valid,
  input  logic                                   q_ready,
  output logic [SAMPLE_BITS+WEIGHT_FRAC_BITS-1:0] q_fv,
  output efps_pkg::mode_t                        q_mode
);

  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int FW = SAMPLE_BITS + F;
  localparam int DW = FW + 1;
  localparam int PW = DW + F + 2;
  localparam logic [PW-1:0] HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_UPD, F_PUSH} state_t;

  state_t                   st;
  logic [FW-1:0]            fv;
  logic                     primed;
  logic [SAMPLE_BITS-1:0]   smp;
  logic                     load;
  logic signed [PW-1:0]     prod;
  logic signed [DW-1:0]     diff;
  logic signed [PW-1:0]     acc;

  assign in_ready = (st == F_IDLE);
  assign q_valid  = (st == F_PUSH);
  assign q_fv     = fv;

  assign diff = $signed({1'b0, smp, {F{1'b0}}}) - $signed({1'b0, fv});
  assign acc  = $signed({{(PW-FW-F){1'b0}}, fv, {F{1'b0}}}) + prod + $signed(HALF);

  always_comb begin
    if (cfg.range_low == '0 && cfg.range_high == '0) begin
      q_mode = efps_pkg::MODE_RAW;
    end else if (cfg.range_low == cfg.range_high) begin
      q_mode = efps_pkg::MODE_ZERO;
    end else if (cfg.range_low > cfg.range_high) begin
      q_mode = efps_pkg::MODE_INVERT;
    end else begin
      q_mode = efps_pkg::MODE_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= F_IDLE;
      fv     <= '0;
      primed <= 1'b0;
    end else begin
      unique case (st)
        F_IDLE: begin
          if (in_valid) begin
            smp  <= raw_sample;
            load <= restart || !primed || weight[F];
            st   <= F_MUL;
          end
        end
        F_MUL: begin
          prod <= $signed({1'b0, weight}) * diff;
          st   <= F_UPD;
        end
        F_UPD: begin
          fv     <= load ? {smp, {F{1'b0}}} : acc[F +: FW];
          primed <= 1'b1;
          st     <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) begin
            st <= F_IDLE;
          end
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

[src/efps_back.sv]
// ----------------------------------------------------------------------------
// efps_back
// Turns a filtered value into a level: raw offset, zero, or percent by serial divide.
// ----------------------------------------------------------------------------
module efps_back #(
  parameter int SAMPLE_BITS      = 12,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  output logic                                    q_ready,
  input  logic [SAMPLE_BITS+WEIGHT_FRAC_BITS-1:0] q_fv,
  input  efps_pkg::mode_t                         q_mode,
  input  efps_pkg::cfg_t                          cfg,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [efps_pkg::LEVEL_BITS-1:0]  level
);

  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int FW   = SAMPLE_BITS + F;
  localparam int LB   = efps_pkg::LOW_BITS;
  localparam int PB   = efps_pkg::PCT_BITS;
  localparam int LVB  = efps_pkg::LEVEL_BITS;
  localparam int VA   = (FW + 1 > LB + F) ? FW + 1 : LB + F;
  localparam int VW   = VA + 1;
  localparam int XW   = LB + F;
  localparam int NW   = XW + PB + 1;
  localparam int DIVN = LB + PB;
  localparam int SH   = F - 8;
  localparam int RW   = FW + 1;
  localparam logic [RW-1:0] RND = (SH > 0) ? RW'(1) << ((SH > 0) ? SH - 1 : 0) : '0;
  localparam int CNW  = $clog2(PB);

  typedef enum logic [2:0] {B_IDLE, B_PREP, B_MUL, B_DIV, B_POST, B_FIN} state_t;

  state_t                   st;
  logic [FW-1:0]            fv;
  efps_pkg::mode_t          mode;
  logic [XW-1:0]            x;
  logic [LB-1:0]            dd;
  logic [LB-1:0]            rem;
  logic [PB-1:0]            quo;
  logic [CNW-1:0]           cnt;
  logic signed [LVB-1:0]    res;

  logic signed [LB-1:0]     lo_s;
  logic signed [LB-1:0]     hi_s;
  logic signed [LB:0]       dsum;
  logic signed [VW-1:0]     lo_f;
  logic signed [VW-1:0]     hi_f;
  logic signed [VW-1:0]     v;
  logic signed [VW-1:0]     vc;
  logic signed [VW-1:0]     xs;
  logic [RW-1:0]            f8;
  logic signed [LVB-1:0]    raw_lvl;
  logic [NW-1:0]            num;
  logic [LB:0]              trial;
  logic                     ge;
  logic [LB:0]              trial_sub;
  logic [PB-1:0]            p_cl;

  assign q_ready = (st == B_IDLE);

  always_comb begin
    lo_s = (mode == efps_pkg::MODE_INVERT) ? cfg.range_high : cfg.range_low;
    hi_s = (mode == efps_pkg::MODE_INVERT) ? cfg.range_low  : cfg.range_high;
    dsum = hi_s - lo_s;
    lo_f = VW'(lo_s) <<< F;
    hi_f = VW'(hi_s) <<< F;
    v    = $signed(VW'({1'b0, fv})) + (VW'(cfg.reading_offset) <<< F);
    if (v < lo_f) begin
      vc = lo_f;
    end else if (v > hi_f) begin
      vc = hi_f;
    end else begin
      vc = v;
    end
    xs      = vc - lo_f;
    f8      = (RW'(fv) + RND) >> SH;
    raw_lvl = $signed(LVB'(f8)) + (LVB'(cfg.reading_offset) <<< 8);
    num     = NW'(x) * NW'(efps_pkg::PERCENT_FULL) + (NW'(dd) << (F - 1));
    trial     = {rem, quo[PB-1]};
    ge        = (trial >= {1'b0, dd});
    trial_sub = trial - {1'b0, dd};
    p_cl      = (quo > efps_pkg::PERCENT_FULL) ? efps_pkg::PERCENT_FULL : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (st == B_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        B_IDLE: begin
          if (q_valid) begin
            fv   <= q_fv;
            mode <= q_mode;
            st   <= B_PREP;
          end
        end
        B_PREP: begin
          x  <= XW'(xs);
          dd <= LB'(dsum);
          unique case (mode)
            efps_pkg::MODE_RAW: begin
              res <= raw_lvl;
              st  <= B_FIN;
            end
            efps_pkg::MODE_ZERO: begin
              res <= '0;
              st  <= B_FIN;
            end
            default: st <= B_MUL;
          endcase
        end
        B_MUL: begin
          rem <= num[F + DIVN - 1 -: LB];
          quo <= num[F +: PB];
          cnt <= '0;
          st  <= B_DIV;
        end
        B_DIV: begin
          rem <= ge ? trial_sub[LB-1:0] : trial[LB-1:0];
          quo <= {quo[PB-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNW'(PB - 1)) begin
            st <= B_POST;
          end
        end
        B_POST: begin
          if (mode == efps_pkg::MODE_INVERT) begin
            res <= $signed(LVB'(efps_pkg::PERCENT_FULL - p_cl));
          end else begin
            res <= $signed(LVB'(p_cl));
          end
          st <= B_FIN;
        end
        B_FIN: begin
          if (!out_valid || out_ready) begin
            level <= res;
            st    <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

endmodule

[src/ema_filter_percent_scaler.sv]
// ----------------------------------------------------------------------------
// ema_filter_percent_scaler
// Moving-average filter of converter samples with range-to-percent scaling.
// The front takes a new sample only after it has queued its previous word;
// the back end runs a 15-step restoring divider in scaled mode and takes
// the next queued word only after finishing the current one.
// Reset: synchronous; clears filter history and loads register reset values.
// ----------------------------------------------------------------------------
module ema_filter_percent_scaler #(
  parameter int SAMPLE_BITS      = 12,
  parameter int WEIGHT_FRAC_BITS = 16,
  localparam int CFG_W = (WEIGHT_FRAC_BITS + 1 > efps_pkg::LOW_BITS) ?
                         WEIGHT_FRAC_BITS + 1 : efps_pkg::LOW_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_en,
  input  logic [efps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_W-1:0]                       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [SAMPLE_BITS-1:0]                 raw_sample,
  input  logic                                   restart,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [efps_pkg::LEVEL_BITS-1:0] level
);

  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int FW = SAMPLE_BITS + F;
  localparam int QW = FW + 2;

  logic [F:0]          weight;
  efps_pkg::cfg_t      cfg;
  logic                fq_valid;
  logic                fq_ready;
  logic [FW-1:0]       fq_fv;
  efps_pkg::mode_t     fq_mode;
  logic                bq_valid;
  logic                bq_ready;
  logic [QW-1:0]       bq_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= {1'b1, {F{1'b0}}};
      cfg    <= '0;
    end else if (cfg_en) begin
      unique case (efps_pkg::cfg_index_t'(cfg_index))
        efps_pkg::CFG_WEIGHT: weight             <= cfg_data[F:0];
        efps_pkg::CFG_LOW:    cfg.range_low      <= cfg_data[efps_pkg::LOW_BITS-1:0];
        efps_pkg::CFG_HIGH:   cfg.range_high     <= cfg_data[efps_pkg::LOW_BITS-1:0];
        efps_pkg::CFG_OFFSET: cfg.reading_offset <= cfg_data[efps_pkg::OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  efps_front #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_sample (raw_sample),
    .restart    (restart),
    .weight     (weight),
    .cfg        (cfg),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_fv       (fq_fv),
    .q_mode     (fq_mode)
  );

  efps_fifo #(
    .W     (QW),
    .DEPTH (efps_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  ({fq_mode, fq_fv}),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_data)
  );

  efps_back #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_fv      (bq_data[FW-1:0]),
    .q_mode    (efps_pkg::mode_t'(bq_data[QW-1:FW])),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level)
  );

endmodule

[src/efps_check.sv]
// ----------------------------------------------------------------------------
// efps_check
// Port-level checks of the scaler handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module efps_check (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [efps_pkg::LEVEL_BITS-1:0] level
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped while stalled");

  a_level_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(level))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front took a word while updating the filter");

endmodule

bind ema_filter_percent_scaler efps_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .level     (level)
);
